>>> sv/dsvs_pkg.sv
// Package for the damped spring vertex step block: types, codes and helpers.
// No dependencies; used by the controller, datapath, top level and testbench.
`timescale 1ns / 1ps
package dsvs_pkg;

  localparam int unsigned QFrac = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 31;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRestLength   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStiffness    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDeadBand     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInverseMass  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFrictionGain = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDragMoving   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDragResting  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSideEnables  = 3'd7;

  typedef struct packed {
    logic        mode;
    logic [31:0] root_x;
    logic [31:0] root_y;
    logic [31:0] root_z;
    logic [15:0] time_step;
    logic [31:0] load_pos_x;
    logic [31:0] load_pos_y;
    logic [31:0] load_pos_z;
    logic [31:0] load_vel_x;
    logic [31:0] load_vel_y;
    logic [31:0] load_vel_z;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_pos_x;
    logic [31:0] new_pos_y;
    logic [31:0] new_pos_z;
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [30:0] distance;
    logic        moving;
  } out_item_t;

  typedef struct packed {
    logic [30:0] rest_length;
    logic [30:0] stiffness;
    logic [30:0] dead_band;
    logic [30:0] inverse_mass;
    logic [30:0] friction_gain;
    logic [30:0] drag_moving;
    logic [30:0] drag_resting;
    logic [1:0]  side_enables;
  } cfg_t;

  // Controller states
  typedef enum logic [3:0] {
    StIdle, StOffset, StSqrt, StDecide, StDiv, StForce, StAccel, StVel, StDrag, StPos,
    StDamp, StOut
  } state_e;

  // Datapath operation codes
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpCapture, OpOffset, OpSqrtInit, OpSqrtStep, OpDecide,
    OpDivInit, OpDivStep, OpForce, OpVel, OpDrag, OpPos, OpDamp
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic moving;
  } stat_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [66:0] hi;
    logic signed [66:0] lo;
    hi = 67'sd2147483647;
    lo = -67'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

>>> sv/dsvs_if.sv
// Valid/ready channel interface carrying one payload per transaction.
// Depends on nothing; payload type supplied by the instantiating module.
`timescale 1ns / 1ps
interface dsvs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/dsvs_ctrl.sv
// Controller state machine sequencing one step through the datapath.
// Depends on dsvs_pkg.
`timescale 1ns / 1ps
module dsvs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_mode_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dsvs_pkg::stat_t stat_i,
  output dsvs_pkg::cmd_t  cmd_o
);
  import dsvs_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;

  // Next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      StIdle: begin
        axis_d = 2'd0;
        if (in_valid_i) state_d = in_mode_i ? StOut : StOffset;
      end
      StOffset: state_d = StSqrt;
      StSqrt:   if (stat_i.sqrt_done) state_d = StDecide;
      StDecide: state_d = stat_i.moving ? StDiv : StDrag;
      StDiv:    if (stat_i.div_done) state_d = StForce;
      StForce:  state_d = StAccel;
      StAccel:  state_d = StVel;
      StVel: begin
        if (axis_q == 2'd2) begin
          state_d = StDrag;
          axis_d  = 2'd0;
        end else begin
          state_d = StDiv;
          axis_d  = axis_q + 2'd1;
        end
      end
      StDrag: state_d = StPos;
      StPos:  state_d = StDamp;
      StDamp: begin
        if (axis_q == 2'd2) begin
          state_d = StOut;
          axis_d  = 2'd0;
        end else begin
          state_d = StPos;
          axis_d  = axis_q + 2'd1;
        end
      end
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op    = OpNone;
    cmd_o.axis  = axis_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = in_mode_i ? OpLoad : OpCapture;
      end
      StOffset: cmd_o.op = OpOffset;
      StSqrt:   cmd_o.op = OpSqrtStep;
      StDecide: cmd_o.op = OpDecide;
      StDiv:    cmd_o.op = stat_i.div_done ? OpNone : OpDivStep;
      StForce:  cmd_o.op = OpForce;
      StAccel:  cmd_o.op = OpNone;   // acceleration register settles
      StVel:    cmd_o.op = OpVel;
      StDrag:   cmd_o.op = OpDrag;
      StPos:    cmd_o.op = OpPos;
      StDamp:   cmd_o.op = OpDamp;
      StOut:    out_valid_o = 1'b1;
      default:  cmd_o.op = OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end
endmodule

>>> sv/dsvs_dp.sv
// Datapath: vertex state, Q16.16 multipliers, bit-serial square root and divider.
// Depends on dsvs_pkg.
`timescale 1ns / 1ps
module dsvs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsvs_pkg::cmd_t      cmd_i,
  input  dsvs_pkg::in_item_t  in_i,
  input  dsvs_pkg::cfg_t      cfg_i,
  output dsvs_pkg::stat_t     stat_o,
  output dsvs_pkg::out_item_t out_o
);
  import dsvs_pkg::*;

  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] frc_q [3];
  logic signed [31:0] off_q [3];
  logic signed [31:0] root_q [3];
  logic [15:0]        dt_q;
  logic [65:0]        rem_q;     // square-root remainder
  logic [65:0]        res_q;     // square-root partial result
  logic [5:0]         sq_cnt_q;  // pair index
  logic [32:0]        root_dist_q;
  logic [30:0]        dist_q;
  logic               moving_q;
  logic signed [31:0] spring_q;
  logic signed [31:0] c_q;
  // Divider for direction: |off|*65536 / root, 48-bit quotient
  logic [47:0]        dvd_q;
  logic [33:0]        drem_q;
  logic [5:0]         dcnt_q;
  logic               dneg_q;
  logic               ddone_q;
  logic signed [31:0] dir_q;
  logic signed [31:0] fric_q;

  // Q16.16 product, floor shift, saturate
  function automatic logic signed [31:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    return sat32(67'(p >>> 16));
  endfunction

  logic [1:0] ax;
  assign ax = cmd_i.axis;

  logic signed [63:0] sq [3];
  logic [65:0]        sumsq;
  logic [31:0]        off_mag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i]      = off_q[i] * off_q[i];
      off_mag[i] = off_q[i][31] ? 32'(-off_q[i]) : 32'(off_q[i]);
    end
    sumsq = {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
  end

  // One square-root step
  logic [65:0] sq_trial;
  logic [65:0] sq_bit;
  logic        sq_take;
  logic [65:0] sq_res_nxt;
  always_comb begin
    sq_bit     = 66'd1 << {sq_cnt_q, 1'b0};
    sq_trial   = res_q + sq_bit;
    sq_take    = (rem_q >= sq_trial);
    sq_res_nxt = sq_take ? (res_q >> 1) + sq_bit : res_q >> 1;
  end

  // One division step
  logic [33:0] drem_sh;
  always_comb drem_sh = {drem_q[32:0], dvd_q[47]};

  logic signed [32:0] len_s, mag_s, tol_s;
  assign len_s = {2'b0, cfg_i.rest_length};
  assign mag_s = {2'b0, dist_q};
  assign tol_s = {2'b0, cfg_i.dead_band};
  logic mv;
  always_comb begin
    mv = !((!cfg_i.side_enables[0] && mag_s <= len_s) ||
           (!cfg_i.side_enables[1] && mag_s >= len_s) ||
           (mag_s >= len_s - tol_s && mag_s <= len_s + tol_s));
  end

  logic signed [31:0] acc;
  logic signed [31:0] rate;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
      moving_q <= 1'b0;
      ddone_q  <= 1'b0;
    end else begin
      case (cmd_i.op)
        OpLoad: begin
          pos_q[0] <= in_i.load_pos_x; pos_q[1] <= in_i.load_pos_y;
          pos_q[2] <= in_i.load_pos_z;
          vel_q[0] <= in_i.load_vel_x; vel_q[1] <= in_i.load_vel_y;
          vel_q[2] <= in_i.load_vel_z;
          for (int i = 0; i < 3; i++) frc_q[i] <= '0;
          dist_q   <= '0;
          moving_q <= 1'b0;
        end
        OpCapture: begin
          root_q[0] <= in_i.root_x; root_q[1] <= in_i.root_y;
          root_q[2] <= in_i.root_z;
          dt_q <= in_i.time_step;
          for (int i = 0; i < 3; i++) frc_q[i] <= '0;
          moving_q <= 1'b0;
        end
        OpOffset: begin
          for (int i = 0; i < 3; i++)
            off_q[i] <= sat32(67'(pos_q[i]) - 67'(root_q[i]));
        end
        OpSqrtStep: begin
          if (sq_cnt_q == 6'd33) begin
            rem_q    <= sumsq;
            res_q    <= '0;
            sq_cnt_q <= 6'd32;
          end else begin
            if (sq_take) rem_q <= rem_q - sq_trial;
            res_q    <= sq_res_nxt;
            sq_cnt_q <= sq_cnt_q - 6'd1;
            // Last step: capture the root and the saturated distance
            if (sq_cnt_q == 6'd0) begin
              root_dist_q <= sq_res_nxt[32:0];
              dist_q      <= (sq_res_nxt > 66'h7fffffff) ? 31'h7fffffff
                                                         : sq_res_nxt[30:0];
            end
          end
        end
        OpDecide: begin
          moving_q <= mv;
          spring_q <= sat32(-67'(mulq({2'b0, cfg_i.stiffness}, mag_s - len_s)));
          ddone_q  <= 1'b0;
          dcnt_q   <= 6'd48;
          drem_q   <= '0;
          dneg_q   <= off_q[0][31];
          dvd_q    <= {off_mag[0], 16'd0};
        end
        OpDivStep: begin
          if (drem_sh >= {1'b0, root_dist_q}) drem_q <= drem_sh - {1'b0, root_dist_q};
          else drem_q <= drem_sh;
          dvd_q <= {dvd_q[46:0], (drem_sh >= {1'b0, root_dist_q})};
          dcnt_q <= dcnt_q - 6'd1;
          if (dcnt_q == 6'd1) ddone_q <= 1'b1;
        end
        OpForce: begin
          frc_q[ax] <= sat32(67'(mulq(dir_q, spring_q)) - 67'(fric_q));
        end
        OpVel: begin
          vel_q[ax] <= sat32(67'(vel_q[ax]) + 67'(mulq(acc, {17'd0, dt_q})));
          ddone_q   <= 1'b0;
          dcnt_q    <= 6'd48;
          drem_q    <= '0;
          if (ax != 2'd2) begin
            dneg_q <= off_q[ax+2'd1][31];
            dvd_q  <= {off_mag[ax+2'd1], 16'd0};
          end
        end
        OpDrag: c_q <= (rate < 0) ? 32'sd0 : (rate > 32'sd65536 ? 32'sd65536 : rate);
        OpPos:  pos_q[ax] <= sat32(67'(pos_q[ax]) + 67'(mulq(vel_q[ax], {17'd0, dt_q})));
        OpDamp: vel_q[ax] <= mulq(vel_q[ax], 33'sd65536 - 33'(c_q));
        default: ;
      endcase
      if (cmd_i.op == OpOffset) sq_cnt_q <= 6'd33;
    end
  end

  // Quotient with sign; zero distance gives zero
  always_comb begin
    if (root_dist_q == '0) dir_q = '0;
    else dir_q = dneg_q ? -dvd_q[31:0] : dvd_q[31:0];
  end

  // Registered helpers: friction and acceleration for the current axis
  always_ff @(posedge clk_i) begin
    fric_q <= mulq({2'b0, cfg_i.friction_gain}, vel_q[ax]);
    acc    <= mulq(frc_q[ax], {2'b0, cfg_i.inverse_mass});
  end
  assign rate = mulq({17'd0, dt_q},
                     {2'b0, moving_q ? cfg_i.drag_moving : cfg_i.drag_resting});

  assign stat_o.sqrt_done = (cmd_i.op == OpSqrtStep) && (sq_cnt_q == 6'd0);
  assign stat_o.div_done  = ddone_q;
  assign stat_o.moving    = mv;

  assign out_o.new_pos_x = pos_q[0];
  assign out_o.new_pos_y = pos_q[1];
  assign out_o.new_pos_z = pos_q[2];
  assign out_o.new_vel_x = vel_q[0];
  assign out_o.new_vel_y = vel_q[1];
  assign out_o.new_vel_z = vel_q[2];
  assign out_o.force_x   = frc_q[0];
  assign out_o.force_y   = frc_q[1];
  assign out_o.force_z   = frc_q[2];
  assign out_o.distance  = dist_q;
  assign out_o.moving    = moving_q;
endmodule

>>> sv/damped_spring_vertex_step_top.sv
// Damped spring vertex step, top level: config registers, controller, datapath.
// A load goes straight to the result; an integrate step runs offset, square root
// and decide, plus three divide/force/velocity passes when spring force applies.
// One item at a time; the next is taken the cycle after the result transaction.
// Asynchronous active-low reset clears vertex state and restores register defaults.
`timescale 1ns / 1ps
module damped_spring_vertex_step_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dsvs_if.sink                          in_if,
  dsvs_if.source                        out_if,
  input  logic                          cfg_we_i,
  input  logic [dsvs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsvs_pkg::CfgDataW-1:0] cfg_data_i
);
  import dsvs_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  in_item_t in_item;
  out_item_t out_item;

  assign in_item = in_if.data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_length   <= 31'd65536;
      cfg_q.stiffness     <= 31'd65536;
      cfg_q.dead_band     <= 31'd32768;
      cfg_q.inverse_mass  <= 31'd655;
      cfg_q.friction_gain <= 31'd6554;
      cfg_q.drag_moving   <= 31'd6554;
      cfg_q.drag_resting  <= 31'd6554;
      cfg_q.side_enables  <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRestLength:   cfg_q.rest_length   <= cfg_data_i;
        RegStiffness:    cfg_q.stiffness     <= cfg_data_i;
        RegDeadBand:     cfg_q.dead_band     <= cfg_data_i;
        RegInverseMass:  cfg_q.inverse_mass  <= cfg_data_i;
        RegFrictionGain: cfg_q.friction_gain <= cfg_data_i;
        RegDragMoving:   cfg_q.drag_moving   <= cfg_data_i;
        RegDragResting:  cfg_q.drag_resting  <= cfg_data_i;
        RegSideEnables:  cfg_q.side_enables  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  dsvs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_mode_i   (in_item.mode),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsvs_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .in_i   (in_item),
    .cfg_i  (cfg_q),
    .stat_o (stat),
    .out_o  (out_item)
  );

  assign out_if.data = out_item;

  // Input only taken while no result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input ready while result pending");
  // Result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed while stalled");
  // Load yields a valid result marked not moving
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && in_item.mode |=> out_if.valid && !out_item.moving)
    else $error("load result wrong");
endmodule

>>> tb/damped_spring_vertex_step_top_tb.sv
// Testbench for damped_spring_vertex_step_top: directed and random Euler steps
// checked against a Q16.16 predictor held here. Depends on dsvs_pkg and dsvs_if.
`timescale 1ns / 1ps
module damped_spring_vertex_step_top_tb;
  import dsvs_pkg::*;

  localparam logic ModeStep = 1'b0;
  localparam logic ModeLoad = 1'b1;
  localparam longint QOne = 65536;
  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dsvs_if #(.payload_t(in_item_t))  in_ch ();
  dsvs_if #(.payload_t(out_item_t)) out_ch ();

  damped_spring_vertex_step_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Vertex state and registers as the block should hold them
  longint vtx_pos [3];
  longint vtx_vel [3];
  cfg_t   spring_cfg;

  out_item_t vertex_results [$];
  int errors;
  int steps_sent;
  int loads_sent;
  int moving_seen;
  int results_seen;
  int burst_left;
  int stall_pct;
  int stall_cnt;
  int idle_cnt;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Q16.16 product, floor shift, saturated
  function automatic longint qmul(longint a, longint b);
    longint pr;
    pr = a * b;
    return clamp_s32(pr >>> 16);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One spring step on the predicted state; returns the expected transaction
  function automatic out_item_t spring_step(in_item_t it);
    out_item_t   res;
    longint      d [3];
    longint      f [3];
    longint      roots [3];
    logic [63:0] sumsq;
    logic [63:0] root;
    longint      mag, len, tol, dt, s, u, rate, c;
    logic        push, pull, mv;
    f = '{0, 0, 0};
    mag = 0;
    mv = 1'b0;
    if (it.mode == ModeLoad) begin
      vtx_pos[0] = longint'($signed(it.load_pos_x));
      vtx_pos[1] = longint'($signed(it.load_pos_y));
      vtx_pos[2] = longint'($signed(it.load_pos_z));
      vtx_vel[0] = longint'($signed(it.load_vel_x));
      vtx_vel[1] = longint'($signed(it.load_vel_y));
      vtx_vel[2] = longint'($signed(it.load_vel_z));
    end else begin
      roots[0] = longint'($signed(it.root_x));
      roots[1] = longint'($signed(it.root_y));
      roots[2] = longint'($signed(it.root_z));
      dt = longint'(it.time_step);
      len = longint'(spring_cfg.rest_length);
      tol = longint'(spring_cfg.dead_band);
      push = spring_cfg.side_enables[0];
      pull = spring_cfg.side_enables[1];
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = clamp_s32(vtx_pos[i] - roots[i]);
        sumsq = sumsq + 64'(d[i] * d[i]);
      end
      root = int_sqrt(sumsq);
      mag = (root > 64'd2147483647) ? 64'sd2147483647 : longint'(root);
      mv = !((!push && mag <= len) || (!pull && mag >= len) ||
             (mag >= len - tol && mag <= len + tol));
      if (mv) begin
        s = clamp_s32(-qmul(longint'(spring_cfg.stiffness), mag - len));
        for (int i = 0; i < 3; i++) begin
          u = (root != 0) ? (d[i] * QOne) / longint'(root) : 0;
          f[i] = clamp_s32(qmul(u, s) -
                           qmul(longint'(spring_cfg.friction_gain), vtx_vel[i]));
          vtx_vel[i] = clamp_s32(vtx_vel[i] +
                         qmul(qmul(f[i], longint'(spring_cfg.inverse_mass)), dt));
        end
      end
      rate = qmul(dt, longint'(mv ? spring_cfg.drag_moving : spring_cfg.drag_resting));
      c = (rate < 0) ? 0 : ((rate > QOne) ? QOne : rate);
      for (int i = 0; i < 3; i++) begin
        vtx_pos[i] = clamp_s32(vtx_pos[i] + qmul(vtx_vel[i], dt));
        vtx_vel[i] = qmul(vtx_vel[i], QOne - c);
      end
    end
    res.new_pos_x = vtx_pos[0][31:0];
    res.new_pos_y = vtx_pos[1][31:0];
    res.new_pos_z = vtx_pos[2][31:0];
    res.new_vel_x = vtx_vel[0][31:0];
    res.new_vel_y = vtx_vel[1][31:0];
    res.new_vel_z = vtx_vel[2][31:0];
    res.force_x = f[0][31:0];
    res.force_y = f[1][31:0];
    res.force_z = f[2][31:0];
    res.distance = mag[30:0];
    res.moving = mv;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Result checker and no-progress watchdog
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (vertex_results.size() == 0) begin
          $error("result transaction with none expected");
          errors++;
        end else begin
          want = vertex_results.pop_front();
          if (got.moving) moving_seen++;
          check_field("new_pos_x", want.new_pos_x, got.new_pos_x);
          check_field("new_pos_y", want.new_pos_y, got.new_pos_y);
          check_field("new_pos_z", want.new_pos_z, got.new_pos_z);
          check_field("new_vel_x", want.new_vel_x, got.new_vel_x);
          check_field("new_vel_y", want.new_vel_y, got.new_vel_y);
          check_field("new_vel_z", want.new_vel_z, got.new_vel_z);
          check_field("force_x", want.force_x, got.force_x);
          check_field("force_y", want.force_y, got.force_y);
          check_field("force_z", want.force_z, got.force_z);
          check_field("distance", 32'(want.distance), 32'(got.distance));
          check_field("moving", 32'(want.moving), 32'(got.moving));
        end
      end
    end
  end

  // Receiver back-pressure: the stall rate is redrawn whenever its hold counter runs out
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_cnt <= 0;
      stall_pct <= 0;
    end else begin
      if (stall_cnt == 0) begin
        stall_cnt <= $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 30;
          2: stall_pct <= 70;
          default: stall_pct <= 95;
        endcase
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Send one transaction, honouring the burst/gap pattern
  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    vertex_results.push_back(spring_step(it));
    if (it.mode == ModeLoad) loads_sent++;
    else steps_sent++;
    burst_left--;
  endtask

  // Let the block go quiet before touching the registers
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (vertex_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_t c);
    logic [30:0] vals [8];
    vals = '{c.rest_length, c.stiffness, c.dead_band, c.inverse_mass,
             c.friction_gain, c.drag_moving, c.drag_resting, 31'(c.side_enables)};
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    spring_cfg = c;
  endtask

  function automatic in_item_t step_item(longint ox, longint oy, longint oz, int dt);
    in_item_t it;
    it = '0;
    it.mode = ModeStep;
    it.root_x = 32'(clamp_s32(vtx_pos[0] + ox));
    it.root_y = 32'(clamp_s32(vtx_pos[1] + oy));
    it.root_z = 32'(clamp_s32(vtx_pos[2] + oz));
    it.time_step = 16'(dt);
    return it;
  endfunction

  function automatic in_item_t load_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                         logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    in_item_t it;
    it = '0;
    it.mode = ModeLoad;
    it.load_pos_x = px; it.load_pos_y = py; it.load_pos_z = pz;
    it.load_vel_x = vx; it.load_vel_y = vy; it.load_vel_z = vz;
    return it;
  endfunction

  function automatic logic [31:0] rnd_fix(int span_units);
    return 32'($signed($urandom_range(0, 2 * span_units * 65536)) - span_units * 65536);
  endfunction

  // Directed: rest and moving cases, zero distance, saturation, dt extremes
  task automatic test_directed;
    cfg_t c;
    c = '{rest_length: 31'(10 * QOne), stiffness: 31'(2 * QOne), dead_band: 31'(QOne / 2),
          inverse_mass: 31'(QOne / 2), friction_gain: 31'(QOne / 4),
          drag_moving: 31'(QOne), drag_resting: 31'(2 * QOne), side_enables: 2'd3};
    write_cfg(c);
    send_item(load_item(0, 0, 0, 0, 0, 0));
    send_item(step_item(0, 0, 0, 4096));                        // zero distance
    send_item(step_item(-3 * QOne, -4 * QOne, 0, 4096));        // compressed, push
    send_item(step_item(-20 * QOne, 0, 0, 8192));               // stretched, pull
    send_item(step_item(0, -10 * QOne, 0, 8192));               // inside dead band
    send_item(step_item(0, 0, -10 * QOne - QOne / 2, 8192));    // band edge
    send_item(step_item(QOne, QOne, QOne, 0));                  // zero time step
    send_item(step_item(-QOne * 7, QOne * 9, 0, 16'hFFFF));     // full time step
    send_item(load_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    send_item(step_item(-64'sd2147483648, 64'sd2147483647, 0, 16'hFFFF));
    send_item(step_item(0, 0, 0, 16'hFFFF));
    send_item(load_item(32'hFFFFFFFF, 0, 1, 32'hFFFFFFFF, 1, 0));
    send_item(step_item(0, 0, 0, 1));
    drain();
    c.side_enables = 2'd0;
    write_cfg(c);
    send_item(load_item(0, 0, 0, 32'(QOne), 0, 0));
    send_item(step_item(-3 * QOne, 0, 0, 4096));                // compressed, no push
    send_item(step_item(-30 * QOne, 0, 0, 4096));               // stretched, no pull
    c.side_enables = 2'd1;
    drain();
    write_cfg(c);
    send_item(step_item(-2 * QOne, 0, 0, 4096));
    send_item(step_item(-40 * QOne, 0, 0, 4096));
    drain();
    c.side_enables = 2'd2;
    write_cfg(c);
    send_item(step_item(-2 * QOne, 0, 0, 4096));
    send_item(step_item(-40 * QOne, 0, 0, 4096));
  endtask

  // Random run: mostly steps near the vertex, some loads, some raw noise
  task automatic test_random(int n_items);
    in_item_t it;
    int sel;
    logic [319:0] raw;
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
      end else if (sel < 18) begin
        it = load_item(rnd_fix(40), rnd_fix(40), rnd_fix(40),
                       rnd_fix(8), rnd_fix(8), rnd_fix(8));
        it.root_x = $urandom;
        it.time_step = 16'($urandom);
      end else begin
        it = step_item(longint'($signed(rnd_fix(30))), longint'($signed(rnd_fix(30))),
                       longint'($signed(rnd_fix(30))),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 8192));
      end
      send_item(it);
    end
  endtask

  task automatic test_cfg_extremes;
    cfg_t c;
    drain();
    c = '{default: 31'h7FFFFFFF, side_enables: 2'd3};
    write_cfg(c);
    test_random(100);
    drain();
    c = '{default: '0, side_enables: 2'd0};
    write_cfg(c);
    test_random(100);
  endtask

  task automatic test_cfg_random(int phases, int per_phase);
    cfg_t c;
    for (int ph = 0; ph < phases; ph++) begin
      drain();
      c.rest_length   = 31'($urandom_range(0, 20 * QOne));
      c.stiffness     = 31'($urandom_range(0, 4 * QOne));
      c.dead_band     = 31'($urandom_range(0, QOne));
      c.inverse_mass  = 31'($urandom_range(0, 2 * QOne));
      c.friction_gain = 31'($urandom_range(0, QOne));
      c.drag_moving   = 31'($urandom_range(0, 4 * QOne));
      c.drag_resting  = 31'($urandom_range(0, 4 * QOne));
      c.side_enables  = 2'($urandom_range(0, 3));
      write_cfg(c);
      test_random(per_phase);
    end
  endtask

  // Main sequence
  initial begin
    errors = 0; steps_sent = 0; loads_sent = 0; moving_seen = 0; results_seen = 0;
    burst_left = 0; idle_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      vtx_pos[i] = 0;
      vtx_vel[i] = 0;
    end
    spring_cfg = '{rest_length: 31'd65536, stiffness: 31'd65536, dead_band: 31'd32768,
                   inverse_mass: 31'd655, friction_gain: 31'd6554, drag_moving: 31'd6554,
                   drag_resting: 31'd6554, side_enables: 2'd0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_random(20);               // reset defaults
    drain();
    test_directed();
    test_cfg_extremes();
    test_cfg_random(7, 200);
    drain();
    $display("Covered %0d integrate steps and %0d loads; %0d results, %0d with spring force.",
             steps_sent, loads_sent, results_seen, moving_seen);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
